// ----- src/assert_macros.svh -----
// assertion macros included by the queue core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed: condition");

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- src/mpq_pkg.sv -----
// shared types, codes and constants of the min priority queue
`timescale 1ns / 1ps
package mpq_pkg;

  // defaults for the top level parameters
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_CHARS_DEF = 8;

  // fixed field widths
  localparam int KEY_W  = 64;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  // operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

  // keeps the top key_chars bytes of a key, clears the rest
  function automatic logic [KEY_W-1:0] key_mask(input int key_chars);
    logic [KEY_W-1:0] low_ones;
    low_ones = (KEY_W'(1) << (KEY_W - 8 * key_chars)) - KEY_W'(1);
    return ~low_ones;
  endfunction

endpackage

// ----- src/mpq_core.sv -----
// queue controller: key memory, linear min scan and hole fill on dequeue
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpq_core
  import mpq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_CHARS = KEY_CHARS_DEF,
  parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [CMD_W-1:0]  req_cmd,
  input  logic [KEY_W-1:0]  req_key,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [KEY_W-1:0]  res_key,
  output logic [STAT_W-1:0] res_status,
  output logic [CNT_W-1:0]  res_count
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam logic [KEY_W-1:0] KEY_MASK = key_mask(KEY_CHARS);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;
  logic [ADDR_W-1:0] best_slot_r, best_slot_nxt;
  logic [KEY_W-1:0]  rd_data_r;

  // memory port controls
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [KEY_W-1:0]  mem_wd;

  logic [KEY_W-1:0] key_mem [CAPACITY];

  logic scan_end;
  logic is_full;
  logic [CNT_W-1:0] last_cnt;

  assign scan_end = !pend_r && (idx_r == count_r);
  assign is_full  = (count_r == CAP_CNT);
  assign last_cnt = count_r - CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          if ((req_cmd == CMD_DEQ || req_cmd == CMD_PEEK) && count_r != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = (cmd_r == CMD_DEQ) ? ST_LAST : ST_DONE;
        end
      end
      ST_LAST: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and memory port outputs
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = count_r[ADDR_W-1:0];
    mem_wd    = req_key & KEY_MASK;
    mem_re    = 1'b0;
    mem_ra    = idx_r[ADDR_W-1:0];
    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        mem_we    = req_valid && (req_cmd == CMD_ENQ) && !is_full;
      end
      ST_SCAN: begin
        if (idx_r < count_r) begin
          mem_re = 1'b1;
        end else if (!pend_r && cmd_r == CMD_DEQ) begin
          // fetch the last entry to fill the hole
          mem_re = 1'b1;
          mem_ra = last_cnt[ADDR_W-1:0];
        end
      end
      ST_LAST: begin
        mem_we = 1'b1;
        mem_wa = best_slot_r;
        mem_wd = rd_data_r;
      end
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    cmd_nxt       = cmd_r;
    status_nxt    = status_r;
    best_key_nxt  = best_key_r;
    best_slot_nxt = best_slot_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          cmd_nxt      = req_cmd;
          status_nxt   = STAT_OK;
          best_key_nxt = '0;
          idx_nxt      = '0;
          pend_nxt     = 1'b0;
          case (req_cmd)
            CMD_ENQ: begin
              if (is_full) begin
                status_nxt = STAT_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DEQ, CMD_PEEK: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // compare the entry read last cycle, first entry always taken
        if (pend_r) begin
          if (idx_r == CNT_W'(1) || rd_data_r < best_key_r) begin
            best_key_nxt  = rd_data_r;
            best_slot_nxt = ADDR_W'(idx_r - CNT_W'(1));
          end
        end
        // issue the next read
        if (idx_r < count_r) begin
          idx_nxt  = idx_r + CNT_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ST_LAST: count_nxt = last_cnt;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    status_r    <= status_nxt;
    best_key_r  <= best_key_nxt;
    best_slot_r <= best_slot_nxt;
  end

  // key memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= key_mem[mem_ra];
    end
  end

  assign res_key    = best_key_r;
  assign res_status = status_r;
  assign res_count  = count_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CAP_CNT)
  `ASSERT_IMP(a_scan_nonempty, clk, rst_n, state_r == ST_SCAN, count_r != '0)
  `ASSERT_IMP(a_full_status, clk, rst_n, res_valid && res_status == STAT_FULL, is_full)
  `ASSERT_IMP(a_empty_status, clk, rst_n, res_valid && res_status == STAT_EMPTY,
              count_r == '0)
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, req_valid && req_ready, state_r != ST_IDLE)

endmodule

// ----- src/min_priority_queue_scan_top.sv -----
// min priority queue over an unsorted key memory; enqueue, an empty queue or the unused code
// go straight to the finish, while peek and dequeue first scan the held entries: the scan reads
// one entry a cycle, then makes the last compare, then dequeue fills the hole with the last
// entry before the finish. a new request is taken once the previous result has moved to the
// output register; sync active-low reset empties the queue and clears the output valid.
`timescale 1ns / 1ps
module min_priority_queue_scan_top
  import mpq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int KEY_CHARS = KEY_CHARS_DEF,
  parameter int CNT_W     = $clog2(CAPACITY + 1),
  parameter int OUT_W     = ((KEY_W + STAT_W + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [71:0]      in_tdata,   // cmd[1:0], key_in[65:2], zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // key_out, status, count_out, zero pad
);

  logic              res_valid, res_ready;
  logic [KEY_W-1:0]  res_key;
  logic [STAT_W-1:0] res_status;
  logic [CNT_W-1:0]  res_count;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  mpq_core #(
    .CAPACITY  (CAPACITY),
    .KEY_CHARS (KEY_CHARS),
    .CNT_W     (CNT_W)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_cmd    (in_tdata[CMD_W-1:0]),
    .req_key    (in_tdata[CMD_W+KEY_W-1:CMD_W]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_key    (res_key),
    .res_status (res_status),
    .res_count  (res_count)
  );

  // output register takes a result when empty or draining
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'({res_count, res_status, res_key});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the min priority queue with a linear scan
`timescale 1ns / 1ps
module tb_top;
  import mpq_pkg::*;

  localparam int QCAP        = CAPACITY_DEF;
  localparam int CNT_W       = $clog2(QCAP + 1);
  localparam int OUT_W       = ((KEY_W + STAT_W + CNT_W + 7) / 8) * 8;
  localparam int WATCH_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = QCAP + 8;
  localparam int RAND_ITEMS  = 600;

  // code the package leaves unnamed: the block treats it as a no-op
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // only the top KEY_CHARS bytes of a key are kept
  localparam logic [KEY_W-1:0] KEEP_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_CHARS_DEF);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } op_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic             typed;
    op_result_t       want;
  } req_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [71:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  // shadow copy of the queue contents
  logic [KEY_W-1:0] shadow_keys [QCAP];
  int unsigned      shadow_count;

  op_result_t op_results_q [$];
  req_row_t   req_table [$];

  int tx_idle_pct;
  int rx_idle_pct;
  bit holdoff_req;
  int fail_count;
  int idle_cycles;
  int n_results;
  int n_enq, n_deq, n_peek, n_unused, n_full, n_empty;

  min_priority_queue_scan_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // applies one request to the shadow queue and returns the result it causes
  function automatic op_result_t queue_op_result(input logic [CMD_W-1:0] op,
                                                 input logic [KEY_W-1:0] key);
    op_result_t  res;
    int unsigned best;
    res.key    = '0;
    res.status = STAT_OK;
    case (op)
      CMD_ENQ: begin
        if (shadow_count >= QCAP) begin
          res.status = STAT_FULL;
        end else begin
          shadow_keys[shadow_count] = key & KEEP_MASK;
          shadow_count++;
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          // lowest slot holding the minimum wins
          best = 0;
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_keys[i] < shadow_keys[best]) best = i;
          end
          res.key = shadow_keys[best];
          if (op == CMD_DEQ) begin
            shadow_keys[best] = shadow_keys[shadow_count - 1];
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(shadow_count);
    return res;
  endfunction

  function automatic req_row_t mk_row(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                      input logic typed, input logic [KEY_W-1:0] key_out,
                                      input logic [STAT_W-1:0] status,
                                      input logic [CNT_W-1:0] count);
    req_row_t row;
    row.cmd         = cmd;
    row.key         = key;
    row.typed       = typed;
    row.want.key    = key_out;
    row.want.status = status;
    row.want.count  = count;
    return row;
  endfunction

  // keys drawn from extremes, short strings with many ties, full random, and random middle bytes
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(9))
      0:       k = '0;
      1:       k = '1;
      2, 3, 4: k = {$urandom, $urandom};
      5, 6, 7: k = {8'h61 + 8'($urandom_range(3)), 8'h61 + 8'($urandom_range(3)), 48'h0};
      default: k = {8'h00, 24'($urandom), 32'h0} | 64'($urandom_range(3));
    endcase
    return k;
  endfunction

  // offers one request, waits for the handshake and records what it should yield
  task automatic send_request(input req_row_t row);
    op_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, row.key, row.cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = queue_op_result(row.cmd, row.key);
    op_results_q.push_back(row.typed ? row.want : res);
    case (row.cmd)
      CMD_ENQ:  n_enq++;
      CMD_DEQ:  n_deq++;
      CMD_PEEK: n_peek++;
      default:  n_unused++;
    endcase
    if (res.status == STAT_FULL) n_full++;
    if (res.status == STAT_EMPTY) n_empty++;
  endtask

  // bursts that lean toward filling, draining or neither
  task automatic run_random(input int n);
    int           lean;
    int           r;
    logic [CMD_W-1:0] c;
    lean = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) lean = $urandom_range(2);
      r = $urandom_range(99);
      case (lean)
        0:       c = r < 70 ? CMD_ENQ : r < 85 ? CMD_DEQ : r < 97 ? CMD_PEEK : CMD_UNUSED;
        1:       c = r < 25 ? CMD_ENQ : r < 75 ? CMD_DEQ : r < 97 ? CMD_PEEK : CMD_UNUSED;
        default: c = r < 45 ? CMD_ENQ : r < 75 ? CMD_DEQ : r < 96 ? CMD_PEEK : CMD_UNUSED;
      endcase
      send_request(mk_row(c, pick_key(), 1'b0, '0, STAT_OK, '0));
    end
  endtask

  // stops offering until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (op_results_q.size() != 0) @(posedge clk);
  endtask

  // result receiver with random stalls and one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    op_result_t got;
    op_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.key    = out_tdata[KEY_W-1:0];
      got.status = out_tdata[KEY_W+STAT_W-1:KEY_W];
      got.count  = out_tdata[KEY_W+STAT_W+CNT_W-1:KEY_W+STAT_W];
      n_results++;
      if (op_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result key %h status %0d count %0d",
                   got.key, got.status, got.count);
      end else begin
        want = op_results_q.pop_front();
        if (got.key !== want.key || got.status !== want.status || got.count !== want.count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch at result %0d: expected key %h status %0d count %0d, got key %h status %0d count %0d",
                     n_results, want.key, want.status, want.count,
                     got.key, got.status, got.count);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", WATCH_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    holdoff_req = 1'b0;
    tx_idle_pct = 19;
    rx_idle_pct = 76;
    fail_count  = 0;
    idle_cycles = 0;
    n_results   = 0;
    n_enq = 0; n_deq = 0; n_peek = 0; n_unused = 0; n_full = 0; n_empty = 0;
    shadow_count = 0;

    // empty queue, extremes, fill to capacity, overflow, tied minima
    req_table.push_back(mk_row(CMD_PEEK,   64'hdead_beef_0123_4567, 1'b1, '0, STAT_EMPTY, 5'd0));
    req_table.push_back(mk_row(CMD_DEQ,    '1,                      1'b1, '0, STAT_EMPTY, 5'd0));
    req_table.push_back(mk_row(CMD_UNUSED, 64'h5a5a_5a5a_a5a5_a5a5, 1'b1, '0, STAT_OK,    5'd0));
    req_table.push_back(mk_row(CMD_ENQ,    '1,                      1'b1, '0, STAT_OK,    5'd1));
    req_table.push_back(mk_row(CMD_ENQ,    '0,                      1'b1, '0, STAT_OK,    5'd2));
    req_table.push_back(mk_row(CMD_PEEK,   '1,                      1'b1, '0, STAT_OK,    5'd2));
    req_table.push_back(mk_row(CMD_ENQ, 64'h6170_706c_6500_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h6170_706c_6500_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h6170_7000_0000_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h7a65_6272_6100_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h0000_0000_0000_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h6100_0000_0000_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h8000_0000_0000_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h7fff_ffff_ffff_ffff, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h6261_6e61_6e61_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h7a7a_7a7a_7a7a_7a7a, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h0000_0000_0000_0001, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h6368_6572_7279_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h6170_7000_0000_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ, 64'h6d61_6e67_6f00_0000, 1'b0, '0, STAT_OK, '0));
    req_table.push_back(mk_row(CMD_ENQ,    64'h6b69_7769_0000_0000, 1'b1, '0, STAT_FULL, 5'd16));
    req_table.push_back(mk_row(CMD_DEQ,    64'h1234_5678_9abc_def0, 1'b1, '0, STAT_OK,   5'd15));
    req_table.push_back(mk_row(CMD_DEQ,    '0,                      1'b1, '0, STAT_OK,   5'd14));
    req_table.push_back(mk_row(CMD_PEEK,   '0,                      1'b0, '0, STAT_OK,   '0));
    req_table.push_back(mk_row(CMD_UNUSED, '1,                      1'b1, '0, STAT_OK,   5'd14));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver mostly stalled
    foreach (req_table[i]) send_request(req_table[i]);
    run_random(RAND_ITEMS);
    drain_results();

    // sender mostly idle, receiver mostly ready
    tx_idle_pct = 76;
    rx_idle_pct = 19;
    run_random(RAND_ITEMS);
    drain_results();

    // no idling, starting with a long receiver hold-off that backs up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holdoff_req = 1'b1;
    run_random(RAND_ITEMS);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d enqueue, %0d dequeue, %0d peek, %0d unused code",
             n_enq + n_deq + n_peek + n_unused, n_enq, n_deq, n_peek, n_unused);
    $display("%0d results checked, %0d full-queue drops, %0d empty-queue replies",
             n_results, n_full, n_empty);
    if (fail_count == 0 && op_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, op_results_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/mpq_pkg.sv
src/mpq_core.sv
src/min_priority_queue_scan_top.sv
tb/sv/tb_top.sv
